@@ rtl/trsa_pkg.sv @@
package trsa_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_HANDLE,
        S_FIND,
        S_RESULT
    } t_state;

    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_FREE     = 3'd1;
    localparam logic [2:0] OP_FIND     = 3'd2;
    localparam logic [2:0] OP_SET_TAG  = 3'd3;
    localparam logic [2:0] OP_COMPLETE = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY       = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE  = 3'd4;
    localparam logic [2:0] ST_UNCOMPLETED = 3'd5;

    localparam logic [1:0] STG_FREE  = 2'd0;
    localparam logic [1:0] STG_INUSE = 2'd1;
    localparam logic [1:0] STG_DONE  = 2'd2;

    localparam logic [1:0] POOL_READ  = 2'd0;
    localparam logic [1:0] POOL_WRITE = 2'd1;
    localparam logic [1:0] POOL_OTHER = 2'd2;

    localparam logic [3:0] KIND_READ   = 4'd0;
    localparam logic [3:0] KIND_WRITE  = 4'd1;
    localparam logic [3:0] KIND_ADMIN  = 4'd2;
    localparam logic [3:0] KIND_FLUSH  = 4'd3;
    localparam logic [3:0] KIND_ISP_IO = 4'd4;
    localparam logic [3:0] KIND_TRIM   = 4'd8;
    localparam logic [3:0] KIND_LAST   = 4'd8;

    // fifo, stage and tag memories are addressed {pool, slot}, the kind memory by slot only; pool code 3 is never used
    localparam int          SLOT_CAP  = 128;
    localparam logic [8:0]  CLEAR_END = 9'd383;

endpackage

@@ rtl/typed_request_slot_allocator_top.sv @@
// sequence: alloc, free, set tag and mark completed go from decode to the alloc or handle state,
// then to result; rejected at decode (bad type, empty pool, bad handle), they go straight to result
// find scans the read, write and other pools in that order and stops at the first hit,
// one slot a cycle through the single tag compare unit on the tag memory read port
// throughput: one item at a time, the next accepted once the result is loaded for output
// reset: synchronous, active low; then a clearing pass over addresses 0 to 383 sweeps the free
// lists, stage, kind and tag memories, during which no item is accepted
module typed_request_slot_allocator_top
    import trsa_pkg::*;
#(
    parameter int READ_POOL_DEPTH  = 64,
    parameter int WRITE_POOL_DEPTH = 64,
    parameter int OTHER_POOL_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_request_kind,
    input  logic [1:0]  i_pool_id,
    input  logic [6:0]  i_slot_index,
    input  logic [15:0] i_queue_id,
    input  logic [15:0] i_command_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_result_pool,
    output logic [6:0]  o_result_slot,
    output logic [3:0]  o_result_kind
);

    localparam logic [7:0] DEPTH_R = 8'(READ_POOL_DEPTH);
    localparam logic [7:0] DEPTH_W = 8'(WRITE_POOL_DEPTH);
    localparam logic [7:0] DEPTH_O = 8'(OTHER_POOL_DEPTH);

    function automatic logic [7:0] depth_of(input logic [1:0] p);
        logic [7:0] d;
        unique case (p)
            POOL_READ:  d = DEPTH_R;
            POOL_WRITE: d = DEPTH_W;
            default:    d = DEPTH_O;
        endcase
        return d;
    endfunction

    // memories, all read at one shared address, with registered read data
    logic [6:0]  r_fifo_mem  [0:383];
    logic [1:0]  r_stage_mem [0:383];
    logic [31:0] r_tag_mem   [0:383];
    logic [3:0]  r_kind_mem  [0:SLOT_CAP-1];
    logic [6:0]  r_fifo_rd;
    logic [1:0]  r_stage_rd;
    logic [31:0] r_tag_rd;
    logic [3:0]  r_kind_rd;

    logic [8:0]  rd_addr;
    logic        fifo_we, stage_we, tag_we, kind_we;
    logic [8:0]  fifo_wa, stage_wa, tag_wa;
    logic [6:0]  fifo_wd, kind_wa;
    logic [1:0]  stage_wd;
    logic [31:0] tag_wd;
    logic [3:0]  kind_wd;

    t_state      r_state, n_state;
    logic [8:0]  r_clr, n_clr;
    logic [7:0]  r_head [0:2];
    logic [7:0]  r_count [0:2];
    logic [7:0]  n_head [0:2];
    logic [7:0]  n_count [0:2];

    // latched item
    logic [2:0]  r_op;
    logic [3:0]  r_kind;
    logic [1:0]  r_pool;
    logic [6:0]  r_slot;
    logic [31:0] r_tag;
    logic [1:0]  r_apool, n_apool;

    // scan pointers: issued address and the one being compared
    logic [1:0]  r_scan_p, n_scan_p, r_cmp_p, n_cmp_p;
    logic [6:0]  r_scan_i, n_scan_i, r_cmp_i, n_cmp_i;
    logic        r_scan_done, n_scan_done, r_cmp_valid, n_cmp_valid;

    // pending result
    logic [2:0]  r_res_status, n_res_status;
    logic [1:0]  r_res_pool, n_res_pool;
    logic [6:0]  r_res_slot, n_res_slot;
    logic [3:0]  r_res_kind, n_res_kind;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [1:0]  r_out_pool;
    logic [6:0]  r_out_slot;
    logic [3:0]  r_out_kind;

    logic        in_acc;
    logic        out_free;
    logic [1:0]  alloc_pool;
    logic [7:0]  hdl_depth;
    logic [8:0]  push_sum;
    logic [7:0]  push_pos;
    logic [7:0]  head_inc;
    logic [7:0]  scan_next;
    logic        kind_scanned;
    logic        tag_hit;
    logic [3:0]  hdl_kind;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign alloc_pool = (r_kind < 4'd2) ? r_kind[1:0] : POOL_OTHER;
    assign hdl_depth  = depth_of(r_pool);
    assign push_sum   = {1'b0, r_head[r_apool]} + {1'b0, r_count[r_apool]};
    assign push_pos   = (push_sum >= {1'b0, depth_of(r_apool)})
                        ? 8'(push_sum - {1'b0, depth_of(r_apool)}) : push_sum[7:0];
    assign head_inc   = r_head[r_apool] + 8'd1;
    assign scan_next  = {1'b0, r_scan_i} + 8'd1;

    // other-pool slots only count in a find for flush, isp io and trim kinds
    assign kind_scanned = (r_cmp_p != POOL_OTHER) || (r_kind_rd == KIND_FLUSH)
                          || (r_kind_rd == KIND_ISP_IO) || (r_kind_rd == KIND_TRIM);
    assign tag_hit = r_cmp_valid && (r_tag_rd == r_tag) && kind_scanned;

    always_comb begin
        unique case (r_pool)
            POOL_READ:  hdl_kind = KIND_READ;
            POOL_WRITE: hdl_kind = KIND_WRITE;
            default:    hdl_kind = r_kind_rd;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_apool      = r_apool;
        n_scan_p     = r_scan_p;
        n_scan_i     = r_scan_i;
        n_scan_done  = r_scan_done;
        n_cmp_p      = r_cmp_p;
        n_cmp_i      = r_cmp_i;
        n_cmp_valid  = r_cmp_valid;
        n_res_status = r_res_status;
        n_res_pool   = r_res_pool;
        n_res_slot   = r_res_slot;
        n_res_kind   = r_res_kind;
        for (int p = 0; p < 3; p++) begin
            n_head[p]  = r_head[p];
            n_count[p] = r_count[p];
        end
        rd_addr  = {r_pool, r_slot};
        fifo_we  = 1'b0;
        fifo_wa  = {r_apool, push_pos[6:0]};
        fifo_wd  = r_slot;
        stage_we = 1'b0;
        stage_wa = {r_pool, r_slot};
        stage_wd = STG_FREE;
        tag_we   = 1'b0;
        tag_wa   = {r_pool, r_slot};
        tag_wd   = r_tag;
        kind_we  = 1'b0;
        kind_wa  = r_fifo_rd;
        kind_wd  = r_kind;

        unique case (r_state)
            S_CLEAR: begin
                fifo_we  = 1'b1;
                fifo_wa  = r_clr;
                fifo_wd  = r_clr[6:0];
                stage_we = 1'b1;
                stage_wa = r_clr;
                stage_wd = STG_FREE;
                tag_we   = 1'b1;
                tag_wa   = r_clr;
                tag_wd   = '0;
                kind_we  = 1'b1;
                kind_wa  = r_clr[6:0];
                kind_wd  = KIND_ADMIN;
                n_clr    = r_clr + 9'd1;
                if (r_clr == CLEAR_END) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_status = ST_BAD_TYPE;
                n_res_pool   = '0;
                n_res_slot   = '0;
                n_res_kind   = '0;
                n_state      = S_RESULT;
                priority case (r_op)
                    OP_ALLOC: begin
                        n_apool = alloc_pool;
                        if (r_kind > KIND_LAST) begin
                            n_res_status = ST_BAD_TYPE;
                        end else if (r_count[alloc_pool] == 8'd0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            rd_addr = {alloc_pool, r_head[alloc_pool][6:0]};
                            n_state = S_ALLOC;
                        end
                    end
                    OP_FREE, OP_SET_TAG, OP_COMPLETE: begin
                        n_apool = r_pool;
                        if (r_pool == 2'd3 || {1'b0, r_slot} >= hdl_depth) begin
                            n_res_status = ST_BAD_HANDLE;
                        end else begin
                            rd_addr = {r_pool, r_slot};
                            n_state = S_HANDLE;
                        end
                    end
                    OP_FIND: begin
                        n_scan_p    = POOL_READ;
                        n_scan_i    = '0;
                        n_scan_done = 1'b0;
                        n_cmp_valid = 1'b0;
                        n_state     = S_FIND;
                    end
                    default: begin
                        n_res_status = ST_BAD_TYPE;
                    end
                endcase
            end
            S_ALLOC: begin
                // pop the oldest free slot of the pool
                n_head[r_apool]  = (head_inc == depth_of(r_apool)) ? 8'd0 : head_inc;
                n_count[r_apool] = r_count[r_apool] - 8'd1;
                stage_we = 1'b1;
                stage_wa = {r_apool, r_fifo_rd};
                stage_wd = STG_INUSE;
                kind_we  = (r_apool == POOL_OTHER);
                kind_wa  = r_fifo_rd;
                n_res_status = ST_OK;
                n_res_pool   = r_apool;
                n_res_slot   = r_fifo_rd;
                n_res_kind   = r_kind;
                n_state      = S_RESULT;
            end
            S_HANDLE: begin
                n_state = S_RESULT;
                if (r_stage_rd == STG_FREE) begin
                    // double free or a handle that was never allocated
                    n_res_status = ST_BAD_HANDLE;
                    n_res_pool   = '0;
                    n_res_slot   = '0;
                    n_res_kind   = '0;
                end else begin
                    n_res_status = ST_OK;
                    n_res_pool   = r_pool;
                    n_res_slot   = r_slot;
                    n_res_kind   = hdl_kind;
                    priority case (r_op)
                        OP_SET_TAG: begin
                            tag_we = 1'b1;
                        end
                        OP_COMPLETE: begin
                            stage_we = 1'b1;
                            stage_wd = STG_DONE;
                        end
                        default: begin
                            if (r_count[r_apool] < hdl_depth) begin
                                fifo_we = 1'b1;
                                n_count[r_apool] = r_count[r_apool] + 8'd1;
                            end
                            stage_we = 1'b1;
                            stage_wd = STG_FREE;
                            if (r_stage_rd != STG_DONE) begin
                                n_res_status = ST_UNCOMPLETED;
                            end
                        end
                    endcase
                end
            end
            S_FIND: begin
                rd_addr     = {r_scan_p, r_scan_i};
                n_cmp_valid = !r_scan_done;
                n_cmp_p     = r_scan_p;
                n_cmp_i     = r_scan_i;
                if (!r_scan_done) begin
                    if (scan_next == depth_of(r_scan_p)) begin
                        n_scan_i = '0;
                        if (r_scan_p == POOL_OTHER) begin
                            n_scan_done = 1'b1;
                        end else begin
                            n_scan_p = r_scan_p + 2'd1;
                        end
                    end else begin
                        n_scan_i = scan_next[6:0];
                    end
                end
                if (tag_hit) begin
                    n_res_status = ST_OK;
                    n_res_pool   = r_cmp_p;
                    n_res_slot   = r_cmp_i;
                    unique case (r_cmp_p)
                        POOL_READ:  n_res_kind = KIND_READ;
                        POOL_WRITE: n_res_kind = KIND_WRITE;
                        default:    n_res_kind = r_kind_rd;
                    endcase
                    n_state = S_RESULT;
                end else if (r_scan_done && !r_cmp_valid) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_pool   = '0;
                    n_res_slot   = '0;
                    n_res_kind   = '0;
                    n_state      = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            r_fifo_mem[fifo_wa] <= fifo_wd;
        end
        if (stage_we) begin
            r_stage_mem[stage_wa] <= stage_wd;
        end
        if (tag_we) begin
            r_tag_mem[tag_wa] <= tag_wd;
        end
        if (kind_we) begin
            r_kind_mem[kind_wa] <= kind_wd;
        end
        r_fifo_rd  <= r_fifo_mem[rd_addr];
        r_stage_rd <= r_stage_mem[rd_addr];
        r_tag_rd   <= r_tag_mem[rd_addr];
        r_kind_rd  <= r_kind_mem[rd_addr[6:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_head[2]   <= '0;
            r_count[0]  <= DEPTH_R;
            r_count[1]  <= DEPTH_W;
            r_count[2]  <= DEPTH_O;
            r_scan_done <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_scan_done <= n_scan_done;
            r_cmp_valid <= n_cmp_valid;
            for (int p = 0; p < 3; p++) begin
                r_head[p]  <= n_head[p];
                r_count[p] <= n_count[p];
            end
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_opcode;
            r_kind <= i_request_kind;
            r_pool <= i_pool_id;
            r_slot <= i_slot_index;
            r_tag  <= {i_queue_id, i_command_id};
        end
        r_apool      <= n_apool;
        r_scan_p     <= n_scan_p;
        r_scan_i     <= n_scan_i;
        r_cmp_p      <= n_cmp_p;
        r_cmp_i      <= n_cmp_i;
        r_res_status <= n_res_status;
        r_res_pool   <= n_res_pool;
        r_res_slot   <= n_res_slot;
        r_res_kind   <= n_res_kind;
        if (r_state == S_RESULT && out_free) begin
            r_out_status <= r_res_status;
            r_out_pool   <= r_res_pool;
            r_out_slot   <= r_res_slot;
            r_out_kind   <= r_res_kind;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_result_pool = r_out_pool;
    assign o_result_slot = r_out_slot;
    assign o_result_kind = r_out_kind;

endmodule
